// ===== rtl/wrpt_pkg.sv =====
// ----------------------------------------------------------------------------
// wrpt_pkg
// shared types and constants for the weighted random pick table
// ----------------------------------------------------------------------------
package wrpt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int VALUE_W         = 16;
  localparam int WEIGHT_W        = 16;
  localparam int FRAC_W          = 16;
  localparam int TOTAL_OUT_W     = 20;
  localparam int COUNT_OUT_W     = 5;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_ADD         = 2'd0,
    CMD_CLEAR       = 2'd1,
    CMD_ROLL        = 2'd2,
    CMD_ROLL_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_ZERO  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [VALUE_W-1:0]  add_value;
    logic [WEIGHT_W-1:0] add_weight;
    logic [FRAC_W-1:0]   random_fraction;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]     picked_value;
    status_t                status;
    logic [TOTAL_OUT_W-1:0] total_weight;
    logic [COUNT_OUT_W-1:0] entry_count;
  } result_t;

  // one table entry as held in the ram
  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

  // flags from the shared compare unit
  typedef struct packed {
    logic hit;   // entry value equals the add value
    logic over;  // running prefix sum passed the scaled fraction
  } unit_flags_t;

endpackage

// ===== rtl/wrpt_ram.sv =====
// ----------------------------------------------------------------------------
// wrpt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module wrpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/wrpt_unit.sv =====
// ----------------------------------------------------------------------------
// wrpt_unit
// shared compare and add unit used once per walked entry
// ----------------------------------------------------------------------------
module wrpt_unit #(
  parameter int SUM_W = 21
) (
  input  wrpt_pkg::entry_t                 entry,
  input  logic [wrpt_pkg::VALUE_W-1:0]     add_value,
  input  logic [wrpt_pkg::WEIGHT_W-1:0]    add_weight,
  input  logic [SUM_W-1:0]                 prefix,
  input  logic [SUM_W+wrpt_pkg::FRAC_W-1:0] target,
  output wrpt_pkg::unit_flags_t            flags,
  output logic [wrpt_pkg::WEIGHT_W-1:0]    merged_weight,
  output logic [wrpt_pkg::WEIGHT_W-1:0]    merge_delta,
  output logic [SUM_W-1:0]                 prefix_next
);

  import wrpt_pkg::*;

  logic [WEIGHT_W:0] wsum_raw;

  always_comb begin
    // merge with saturation
    wsum_raw      = {1'b0, entry.weight} + {1'b0, add_weight};
    merged_weight = wsum_raw[WEIGHT_W] ? WEIGHT_MAX : wsum_raw[WEIGHT_W-1:0];
    merge_delta   = merged_weight - entry.weight;
    flags.hit     = (entry.value == add_value);
    // running prefix against the scaled fraction
    prefix_next   = prefix + {{(SUM_W-WEIGHT_W){1'b0}}, entry.weight};
    flags.over    = ({prefix_next, {FRAC_W{1'b0}}} > target);
  end

endmodule

// ===== rtl/weighted_random_pick_table.sv =====
// operation: an item is taken in the idle state, then walks the table one entry per cycle
// (add: up to a match or the last entry, roll: up to the pick, roll and remove: on to the end
// to close the gap), then finishes in the done state, which waits while a held result stalls
// throughput: one item at a time, bound by the single ram read port and the shared unit
// clear, refused adds and rolls of an empty table go from idle straight to the done state
// reset: synchronous, clears count, total, state and result valid; the ram is not cleared
// ----------------------------------------------------------------------------
// weighted_random_pick_table
// value and weight table with weighted random pick (roulette wheel), one
// shared compare unit stepped over the entries by a small sequencer
// ----------------------------------------------------------------------------
module weighted_random_pick_table #(
  parameter int TABLE_DEPTH = wrpt_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  wrpt_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output wrpt_pkg::result_t result
);

  import wrpt_pkg::*;

  // address, count and sum widths
  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_W = WEIGHT_W + CW;
  localparam int TGT_W = SUM_W + FRAC_W;

  // sequencer and latched word
  state_t                state, state_next;
  cmd_t                  cmd_q, cmd_q_next;
  logic [VALUE_W-1:0]    val_q, val_q_next;
  logic [WEIGHT_W-1:0]   wt_q, wt_q_next;
  logic [TGT_W-1:0]      target, target_next;

  // walk position and running prefix
  logic [CW-1:0]         idx, idx_next;
  logic [CW-1:0]         idx_plus1, idx_minus1;
  logic [SUM_W-1:0]      prefix, prefix_next;

  // table bookkeeping
  logic [CW-1:0]         count, count_next;
  logic [SUM_W-1:0]      wsum, wsum_next;

  // pending result fields
  logic [VALUE_W-1:0]    res_picked, res_picked_next;
  status_t               res_status, res_status_next;

  // output register
  logic                  result_valid_next;
  result_t               result_next;

  // ram port
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  entry_t                ram_wdata, ram_rdata;

  // shared unit
  unit_flags_t           flags;
  logic [WEIGHT_W-1:0]   merged_weight, merge_delta;
  logic [SUM_W-1:0]      unit_prefix;

  logic                  last_entry;

  wrpt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wrpt_unit #(
    .SUM_W (SUM_W)
  ) u_unit (
    .entry         (ram_rdata),
    .add_value     (val_q),
    .add_weight    (wt_q),
    .prefix        (prefix),
    .target        (target),
    .flags         (flags),
    .merged_weight (merged_weight),
    .merge_delta   (merge_delta),
    .prefix_next   (unit_prefix)
  );

  assign idx_plus1  = idx + CW'(1);
  assign idx_minus1 = idx - CW'(1);
  assign last_entry = (idx_plus1 == count);
  assign item_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      wsum         <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      wsum         <= wsum_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q      <= cmd_q_next;
    val_q      <= val_q_next;
    wt_q       <= wt_q_next;
    target     <= target_next;
    idx        <= idx_next;
    prefix     <= prefix_next;
    res_picked <= res_picked_next;
    res_status <= res_status_next;
    result     <= result_next;
  end

  always_comb begin
    state_next        = state;
    cmd_q_next        = cmd_q;
    val_q_next        = val_q;
    wt_q_next         = wt_q;
    target_next       = target;
    idx_next          = idx;
    prefix_next       = prefix;
    count_next        = count;
    wsum_next         = wsum;
    res_picked_next   = res_picked;
    res_status_next   = res_status;
    result_next       = result;
    // a waiting result drops once taken
    result_valid_next = result_valid && result_stall;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    // the walk always prefetches the next entry
    ram_raddr = (state == S_IDLE) ? '0 : idx_plus1[AW-1:0];

    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd_q_next      = item.cmd;
          val_q_next      = item.add_value;
          wt_q_next       = item.add_weight;
          // scaled fraction, r times the total
          target_next     = {{SUM_W{1'b0}}, item.random_fraction}
                          * {{FRAC_W{1'b0}}, wsum};
          idx_next        = '0;
          prefix_next     = '0;
          res_picked_next = '0;
          res_status_next = STAT_OK;
          state_next      = S_DONE;
          case (item.cmd)
            CMD_ADD: begin
              if (count == CW'(TABLE_DEPTH)) begin
                // full table refuses merges too
                res_status_next = STAT_FULL;
              end else if (item.add_weight == '0) begin
                res_status_next = STAT_ZERO;
              end else if (count == '0) begin
                // nothing to merge with, append at once
                ram_we           = 1'b1;
                ram_waddr        = '0;
                ram_wdata.value  = item.add_value;
                ram_wdata.weight = item.add_weight;
                count_next       = CW'(1);
                wsum_next        = {{(SUM_W-WEIGHT_W){1'b0}}, item.add_weight};
              end else begin
                state_next = S_SCAN;
              end
            end
            CMD_CLEAR: begin
              count_next = '0;
              wsum_next  = '0;
            end
            CMD_ROLL, CMD_ROLL_REMOVE: begin
              if (count == '0) begin
                res_status_next = STAT_EMPTY;
              end else begin
                state_next = S_SCAN;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (cmd_q == CMD_ADD) begin
          if (flags.hit) begin
            // merge into the matching entry
            ram_we           = 1'b1;
            ram_waddr        = idx[AW-1:0];
            ram_wdata.value  = val_q;
            ram_wdata.weight = merged_weight;
            wsum_next        = wsum + {{(SUM_W-WEIGHT_W){1'b0}}, merge_delta};
            state_next       = S_DONE;
          end else if (last_entry) begin
            // no match, append behind the last entry
            ram_we           = 1'b1;
            ram_waddr        = count[AW-1:0];
            ram_wdata.value  = val_q;
            ram_wdata.weight = wt_q;
            count_next       = count + CW'(1);
            wsum_next        = wsum + {{(SUM_W-WEIGHT_W){1'b0}}, wt_q};
            state_next       = S_DONE;
          end else begin
            idx_next = idx_plus1;
          end
        end else begin
          if (flags.over || last_entry) begin
            res_picked_next = ram_rdata.value;
            state_next      = S_DONE;
            if (cmd_q == CMD_ROLL_REMOVE) begin
              wsum_next = wsum - {{(SUM_W-WEIGHT_W){1'b0}}, ram_rdata.weight};
              if (last_entry) begin
                count_next = count - CW'(1);
              end else begin
                // close the gap, entry idx+1 is already on its way
                idx_next   = idx_plus1;
                state_next = S_SHIFT;
              end
            end
          end else begin
            prefix_next = unit_prefix;
            idx_next    = idx_plus1;
          end
        end
      end

      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_minus1[AW-1:0];
        ram_wdata = ram_rdata;
        if (last_entry) begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end else begin
          idx_next = idx_plus1;
        end
      end

      S_DONE: begin
        if (!result_valid || !result_stall) begin
          result_next.picked_value = res_picked;
          result_next.status       = res_status;
          result_next.total_weight = TOTAL_OUT_W'(wsum);
          result_next.entry_count  = COUNT_OUT_W'(count);
          result_valid_next        = 1'b1;
          state_next               = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // count stays within the table
  assert property (@(posedge clk) disable iff (rst) count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // stored weights are never zero, so an empty table has no weight
  assert property (@(posedge clk) disable iff (rst) (count == '0) |-> (wsum == '0))
    else $error("empty table with nonzero total weight");

  // an empty roll reports no pick and no entries
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STAT_EMPTY) |->
      (result.picked_value == '0 && result.entry_count == '0))
    else $error("empty roll with a pick or entries");

  // a new word appears only out of the finishing step
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the finishing step");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the weighted random pick table: a shadow copy of
// the table predicts every answer, directed words cover the corner cases and
// a long random run with bursty input and an irregular, sometimes very long,
// output stall covers the rest
// ----------------------------------------------------------------------------
module tb_top;
  import wrpt_pkg::*;

  localparam int DEPTH        = TABLE_DEPTH_DEF;
  localparam int RANDOM_WORDS = 500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;

  // shadow of the table contents plus the answers still owed by the block
  class pick_table_shadow;
    logic [VALUE_W-1:0]  values  [DEPTH];
    logic [WEIGHT_W-1:0] weights [DEPTH];
    int unsigned         count;
    int unsigned         total;
    result_t             owed_results [$];
    int unsigned         mismatches;

    // applies one command to the shadow table and returns the answer it gives
    function result_t apply_command(item_t word);
      result_t         res;
      int unsigned     merged;
      int unsigned     k;
      bit              found;
      longint unsigned target;
      longint unsigned prefix;
      res = '0;
      res.status = STAT_OK;
      case (word.cmd)
        CMD_ADD: begin
          if (count >= DEPTH) begin
            res.status = STAT_FULL;
          end else if (word.add_weight == '0) begin
            res.status = STAT_ZERO;
          end else begin
            found = 1'b0;
            for (int i = 0; i < count && !found; i++) begin
              if (values[i] == word.add_value) begin
                merged = weights[i] + word.add_weight;
                if (merged > WEIGHT_MAX) merged = WEIGHT_MAX;
                total += merged - weights[i];
                weights[i] = WEIGHT_W'(merged);
                found = 1'b1;
              end
            end
            if (!found) begin
              values[count]  = word.add_value;
              weights[count] = word.add_weight;
              count++;
              total += word.add_weight;
            end
          end
        end
        CMD_CLEAR: begin
          count = 0;
          total = 0;
        end
        default: begin
          if (count == 0) begin
            res.status = STAT_EMPTY;
          end else begin
            // first entry whose prefix sum, scaled by 2^16, passes r * total
            target = 64'(word.random_fraction) * 64'(total);
            prefix = 0;
            k      = count - 1;
            found  = 1'b0;
            for (int i = 0; i < count && !found; i++) begin
              prefix += weights[i];
              if ((prefix << 16) > target) begin
                k     = i;
                found = 1'b1;
              end
            end
            res.picked_value = values[k];
            if (word.cmd == CMD_ROLL_REMOVE) begin
              total -= weights[k];
              for (int i = k; i + 1 < count; i++) begin
                values[i]  = values[i+1];
                weights[i] = weights[i+1];
              end
              count--;
            end
          end
        end
      endcase
      res.total_weight = TOTAL_OUT_W'(total);
      res.entry_count  = COUNT_OUT_W'(count);
      return res;
    endfunction

    function void note_item(item_t word);
      owed_results.push_back(apply_command(word));
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (owed_results.size() == 0) begin
        $error("result word with nothing owed: %h", got);
        mismatches++;
        return;
      end
      exp = owed_results.pop_front();
      if (got.picked_value !== exp.picked_value) begin
        $error("picked_value: expected %h, got %h", exp.picked_value, got.picked_value);
        mismatches++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        mismatches++;
      end
      if (got.total_weight !== exp.total_weight) begin
        $error("total_weight: expected %0d, got %0d", exp.total_weight, got.total_weight);
        mismatches++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp.entry_count, got.entry_count);
        mismatches++;
      end
    endfunction
  endclass

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  pick_table_shadow shadow = new();

  // sender burst bookkeeping
  int unsigned burst_left = 0;

  // receiver bookkeeping
  int unsigned results_taken = 0;
  int unsigned hold_left     = 0;
  bit          held_once     = 1'b0;
  int unsigned stall_mode    = 0;
  int unsigned mode_left     = 0;
  int unsigned stall_phase   = 0;

  int unsigned cycles = 0;

  weighted_random_pick_table #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[weighted_random_pick_table] ERROR");
      $finish;
    end
  end

  // receiver: take and check result words, then choose the next stall value
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        shadow.check_result(result);
        results_taken++;
      end
      if (hold_left != 0) begin
        // long hold-off still running
        hold_left--;
        result_stall <= 1'b1;
      end else if (!held_once && results_taken >= 60) begin
        // one long hold-off so the block backs up and stalls its input
        held_once = 1'b1;
        hold_left = 400;
        result_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 150);
        end
        mode_left--;
        stall_phase++;
        case (stall_mode)
          0:       result_stall <= 1'b0;                        // free flowing
          1:       result_stall <= ($urandom_range(0, 3) == 0); // light
          2:       result_stall <= ($urandom_range(0, 3) != 0); // heavy
          default: result_stall <= stall_phase[1];              // regular on/off
        endcase
      end
    end
  end

  function automatic item_t pack_item(cmd_t cmd, logic [VALUE_W-1:0] v,
                                      logic [WEIGHT_W-1:0] w, logic [FRAC_W-1:0] r);
    item_t word;
    word.cmd             = cmd;
    word.add_value       = v;
    word.add_weight      = w;
    word.random_fraction = r;
    return word;
  endfunction

  // offer one word until taken, then maybe pause between bursts
  task automatic offer(input item_t word);
    int unsigned gap;
    item       <= word;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    shadow.note_item(word);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // mostly short bursts, now and then a long unbroken stretch
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 12);
      gap = $urandom_range(1, 7);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    item_t       word;
    int unsigned sel;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part
    // rolls of an empty table
    offer(pack_item(CMD_ROLL,        16'h0000, 16'h0000, 16'h0000));
    offer(pack_item(CMD_ROLL_REMOVE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // zero weight is ignored
    offer(pack_item(CMD_ADD,         16'h1234, 16'h0000, 16'h0000));
    // extreme weight, then a merge that saturates and leaves the total alone
    offer(pack_item(CMD_ADD,         16'h0000, 16'hFFFF, 16'h0000));
    offer(pack_item(CMD_ADD,         16'h0000, 16'h0001, 16'h0000));
    offer(pack_item(CMD_ADD,         16'hFFFF, 16'h0001, 16'h0000));
    // lowest fraction picks the first entry, highest the last
    offer(pack_item(CMD_ROLL,        16'h0000, 16'h0000, 16'h0000));
    offer(pack_item(CMD_ROLL_REMOVE, 16'h0000, 16'h0000, 16'hFFFF));
    // fill the table with maximum weights, total at its largest
    for (int i = 1; i < DEPTH; i++) begin
      offer(pack_item(CMD_ADD, 16'(i) * 16'h1111, 16'hFFFF, 16'h0000));
    end
    // full table refuses a merge and a zero weight alike
    offer(pack_item(CMD_ADD,         16'h0000, 16'h0005, 16'h0000));
    offer(pack_item(CMD_ADD,         16'h4321, 16'h0000, 16'h0000));
    // remove from the middle so the gap is closed, then clear
    offer(pack_item(CMD_ROLL_REMOVE, 16'h0000, 16'h0000, 16'h8000));
    offer(pack_item(CMD_CLEAR,       16'h0000, 16'h0000, 16'h0000));

    // random part: adds outweigh removals so the table often fills up,
    // a small value pool makes merges common
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50)      word.cmd = CMD_ADD;
      else if (sel < 72) word.cmd = CMD_ROLL;
      else if (sel < 97) word.cmd = CMD_ROLL_REMOVE;
      else               word.cmd = CMD_CLEAR;
      word.add_value = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 11));
      sel = $urandom_range(0, 9);
      case (sel)
        0:       word.add_weight = 16'h0000;
        1:       word.add_weight = 16'hFFFF;
        2, 3:    word.add_weight = 16'($urandom);
        default: word.add_weight = 16'($urandom_range(1, 4000));
      endcase
      sel = $urandom_range(0, 9);
      case (sel)
        0:       word.random_fraction = 16'h0000;
        1:       word.random_fraction = 16'hFFFF;
        default: word.random_fraction = 16'($urandom);
      endcase
      offer(word);
    end
    item_valid <= 1'b0;

    // drain, then give the block time to show any stray result word
    while (shadow.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (shadow.mismatches == 0) begin
      $display("[weighted_random_pick_table] OK");
    end else begin
      $display("[weighted_random_pick_table] ERROR");
    end
    $finish;
  end

endmodule
